>>> sv/b2ahd_pkg.sv
// Shared types, constants and character helpers for the binary to ASCII formatter.
`timescale 1ns / 1ps

package b2ahd_pkg;

  // Width of the number that is formatted; input bits above it are ignored.
  localparam int VALUE_BITS   = 64;
  // Width of the value field on the input port.
  localparam int IN_BITS      = 64;
  localparam int NIBBLE_COUNT = (VALUE_BITS + 3) / 4;
  localparam int HEX_BITS     = 4 * NIBBLE_COUNT;
  localparam int DEC_DIGITS   = 20;
  localparam int BCD_BITS     = 4 * DEC_DIGITS;
  localparam int CHAR_W       = 7;

  localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CH_X    = 7'h78;
  localparam logic [CHAR_W-1:0] CH_A    = 7'h61;

  // Format select carried by each request.
  typedef enum logic {
    CMD_HEX = 1'b0,
    CMD_DEC = 1'b1
  } cmd_t;

  // One classified request as it travels from front to back.
  typedef struct packed {
    cmd_t                  cmd;
    logic [VALUE_BITS-1:0] val;
  } req_t;

  // Maps one nibble or decimal digit to its lowercase ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {3'b000, d};
    if (d < 4'd10) begin
      digit_char = CH_ZERO + dx;
    end else begin
      digit_char = CH_A + dx - 7'd10;
    end
  endfunction

endpackage

>>> sv/b2ahd_front.sv
// Front end: accepts requests, masks the value and selects the format.
`timescale 1ns / 1ps

module b2ahd_front (
  input  logic                           push,
  input  logic                           command,
  input  logic [b2ahd_pkg::IN_BITS-1:0]  value,
  output logic                           full,
  input  logic                           q_full,
  output logic                           q_wr,
  output b2ahd_pkg::req_t                q_data
);
  import b2ahd_pkg::*;

  // The request queue applies back pressure directly.
  assign full = q_full;
  assign q_wr = push && !q_full;

  // Classify the request and keep only the formatted bits of the value.
  always_comb begin
    q_data.cmd = command ? CMD_DEC : CMD_HEX;
    q_data.val = value[VALUE_BITS-1:0];
  end

endmodule

>>> sv/b2ahd_queue.sv
// Two-entry request queue between the front end and the conversion engine.
`timescale 1ns / 1ps

module b2ahd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  b2ahd_pkg::req_t wr_data,
  input  logic            rd,
  output logic            valid,
  output logic            full,
  output b2ahd_pkg::req_t rd_data
);
  import b2ahd_pkg::*;

  req_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign valid   = (count != 2'd0);
  assign full    = (count == 2'd2);
  assign rd_data = mem[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      wr_ptr <= wr_ptr ^ wr;
      rd_ptr <= rd_ptr ^ rd;
      count  <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> sv/b2ahd_back.sv
// Conversion engine: hex nibble emitter, serial binary to BCD converter and result register.
`timescale 1ns / 1ps

module b2ahd_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  b2ahd_pkg::req_t                     q_data,
  output logic                                q_rd,
  input  logic                                pop,
  output logic                                empty,
  output logic [b2ahd_pkg::CHAR_W-1:0]        ascii_char,
  output logic                                last
);
  import b2ahd_pkg::*;

  localparam int BIT_W     = $clog2(VALUE_BITS);
  localparam int DIG_W     = $clog2(DEC_DIGITS + 1);
  localparam int HEX_POS_W = $clog2(NIBBLE_COUNT + 2);
  localparam logic [HEX_POS_W-1:0] HEX_LAST = HEX_POS_W'(NIBBLE_COUNT + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_EMIT_DEC,
    S_EMIT_HEX
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] bin;
  logic [BCD_BITS-1:0]   bcd;
  logic [BCD_BITS-1:0]   bcd_adj;
  logic [HEX_BITS-1:0]   hexsh;
  logic [BIT_W-1:0]      bit_cnt;
  logic [DIG_W-1:0]      dig_cnt;
  logic [HEX_POS_W-1:0]  hex_pos;
  logic                  out_valid;
  logic                  out_free;
  logic [3:0]            top_digit;
  logic [3:0]            top_nibble;

  assign empty      = !out_valid;
  assign out_free   = !out_valid || pop;
  assign q_rd       = (state == S_IDLE) && q_valid;
  assign top_digit  = bcd[BCD_BITS-1 -: 4];
  assign top_nibble = hexsh[HEX_BITS-1 -: 4];

  // Add three to every BCD digit of five or more ahead of the shift.
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // Sequencer with the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_data.cmd == CMD_DEC) begin
              bin     <= q_data.val;
              bcd     <= '0;
              bit_cnt <= BIT_W'(VALUE_BITS - 1);
              state   <= S_CONV;
            end else begin
              hexsh   <= HEX_BITS'(q_data.val);
              hex_pos <= '0;
              state   <= S_EMIT_HEX;
            end
          end
        end
        S_CONV: begin
          bcd <= {bcd_adj[BCD_BITS-2:0], bin[VALUE_BITS-1]};
          bin <= {bin[VALUE_BITS-2:0], 1'b0};
          if (bit_cnt == '0) begin
            dig_cnt <= DIG_W'(DEC_DIGITS);
            state   <= S_SKIP;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        S_SKIP: begin
          // Drop leading zeros, but keep the final digit for a value of zero.
          if (top_digit == 4'd0 && dig_cnt != DIG_W'(1)) begin
            bcd     <= {bcd[BCD_BITS-5:0], 4'd0};
            dig_cnt <= dig_cnt - 1'b1;
          end else begin
            state <= S_EMIT_DEC;
          end
        end
        S_EMIT_DEC: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            ascii_char <= digit_char(top_digit);
            last       <= (dig_cnt == DIG_W'(1));
            bcd        <= {bcd[BCD_BITS-5:0], 4'd0};
            dig_cnt    <= dig_cnt - 1'b1;
            if (dig_cnt == DIG_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        S_EMIT_HEX: begin
          if (out_free) begin
            out_valid <= 1'b1;
            last      <= (hex_pos == HEX_LAST);
            hex_pos   <= hex_pos + 1'b1;
            if (hex_pos == HEX_POS_W'(0)) begin
              ascii_char <= CH_ZERO;
            end else if (hex_pos == HEX_POS_W'(1)) begin
              ascii_char <= CH_X;
            end else begin
              ascii_char <= digit_char(top_nibble);
              hexsh      <= {hexsh[HEX_BITS-5:0], 4'd0};
            end
            if (hex_pos == HEX_LAST) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/binary_to_ascii_hex_dec.sv
// Top level of the binary to ASCII hexadecimal and decimal formatter.
//
//  Channel   Handshake         Payload
//  request   push / full       command (1), value (64)
//  result    pop / empty       ascii_char (7), last (1)
//
// A hex request moves from idle to emitting and then emits 18 characters, one per cycle
// while results are taken.
// A decimal request first runs all 64 value bits through the serial BCD converter, then
// drops each leading zero but the last digit and emits the remaining digits, one per cycle
// while results are taken, so each of the 20 digit places is either dropped or emitted.
// Two requests can wait in the queue while the engine works on a third.
// Reset is synchronous and empties the queue and the result register.
// A stalled result holds the engine but not the request side until the queue fills.
`timescale 1ns / 1ps

module binary_to_ascii_hex_dec (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic                              command,
  input  logic [b2ahd_pkg::IN_BITS-1:0]     value,
  output logic                              empty,
  input  logic                              pop,
  output logic [b2ahd_pkg::CHAR_W-1:0]      ascii_char,
  output logic                              last
);
  import b2ahd_pkg::*;

  logic q_full;
  logic q_wr;
  logic q_rd;
  logic q_valid;
  req_t q_wr_data;
  req_t q_rd_data;

  // Request intake.
  b2ahd_front u_front (
    .push    (push),
    .command (command),
    .value   (value),
    .full    (full),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_data  (q_wr_data)
  );

  // Decoupling queue.
  b2ahd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .rd      (q_rd),
    .valid   (q_valid),
    .full    (q_full),
    .rd_data (q_rd_data)
  );

  // Conversion and character output.
  b2ahd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_rd_data),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .ascii_char (ascii_char),
    .last       (last)
  );

`ifndef NO_ASSERTIONS
  // A full queue always has a request for the engine.
  a_full_valid: assert property (@(posedge clk) disable iff (rst) full |-> q_valid)
    else $error("queue full without a valid entry");

  // The engine only takes a request that is there.
  a_rd_valid: assert property (@(posedge clk) disable iff (rst) q_rd |-> q_valid)
    else $error("queue read while empty");

  // Reset leaves no result waiting.
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // An accepted request cannot be dropped: a queue write never meets a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_wr |-> !q_full)
    else $error("queue written while full");
`endif

endmodule
